// ----- src/fsd_pkg.sv -----
package fsd_pkg;

  // frame header layout
  localparam int unsigned HDR_LEN  = 9;
  localparam int unsigned CNT_W    = 4;
  localparam int unsigned LEN_W    = 24;
  localparam int unsigned SID_W    = 31;

  localparam logic [LEN_W-1:0] MAX_FRAME_RESET = 24'd16384;

  // result kinds
  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_t;

  // one result item
  typedef struct packed {
    kind_t             kind;
    logic [LEN_W-1:0]  frame_length;
    logic [7:0]        frame_type;
    logic [7:0]        frame_flags;
    logic [SID_W-1:0]  sid;
    logic [7:0]        data_byte;
    logic              last_of_frame;
  } res_t;

endpackage

// ----- src/fsd_skid.sv -----
module fsd_skid
  import fsd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  input  res_t push_data,
  output logic push_ready,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_data
);

  logic out_valid_r;
  logic skid_valid_r;
  res_t out_r;
  res_t skid_r;

  // room for a new item while the skid slot is empty
  assign push_ready = !skid_valid_r;
  assign out_valid  = out_valid_r;
  assign out_data   = out_r;

  // control: output register refills from the skid slot first
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r  <= push_valid;
      end
    end else if (push_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (!out_valid_r || out_ready) begin
      if (skid_valid_r) begin
        out_r <= skid_r;
      end else if (push_valid) begin
        out_r <= push_data;
      end
    end else if (push_valid) begin
      skid_r <= push_data;
    end
  end

`ifndef SYNTH
  // skid slot is only used behind a held output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid slot full while output empty");

  // no push lands while the skid slot is occupied
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    push_valid |-> !skid_valid_r)
    else $error("push into full skid stage");

  // a taken output with a held skid item moves it forward
  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r && out_ready |=> out_valid_r && !skid_valid_r)
    else $error("skid item not forwarded");
`endif

endmodule

// ----- src/frame_stream_deframer_top.sv -----
// Streaming frame deframer: takes one stream byte per item and collects the
// 9-byte frame header (24-bit big-endian length, type, flags, 31-bit stream
// id with the reserved bit cleared). On the ninth byte it emits a header
// item, or a frame size error item if the length exceeds cfg max frame size,
// after which every byte is dropped until reset. Payload bytes are then
// passed through one per item with the header fields and a last-of-frame
// mark; a zero-length header carries the mark itself. One byte is taken per
// clock: each byte is decoded in the cycle it is accepted and its result
// goes to an output register backed by a one-entry skid register, so
// in_ready only drops when both of those hold an item that has not been
// taken. The maximum frame size is checked when a header completes.
module frame_stream_deframer_top
  import fsd_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [LEN_W-1:0]    cfg_wr_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_byte,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          out_kind,
  output logic [LEN_W-1:0]    out_frame_length,
  output logic [7:0]          out_frame_type,
  output logic [7:0]          out_frame_flags,
  output logic [SID_W-1:0]    out_sid,
  output logic [7:0]          out_data_byte,
  output logic                out_last_of_frame
);

  logic [LEN_W-1:0] max_size_r;
  logic [CNT_W-1:0] hdr_cnt_r, hdr_cnt_nxt;
  logic [7:0]       hdr_r [0:HDR_LEN-1];
  logic [LEN_W-1:0] rem_r, rem_nxt;
  logic             in_payload_r, in_payload_nxt;
  logic             failed_r, failed_nxt;

  logic             accept;
  logic             hdr_done;
  logic             push_valid;
  logic             push_ready;
  res_t             res;
  res_t             out_res;
  logic [LEN_W-1:0] len_view;
  logic [SID_W-1:0] sid_view;
  logic [7:0]       last_byte;

  assign in_ready = push_ready;
  assign accept   = in_valid && push_ready;
  assign hdr_done = !in_payload_r && (hdr_cnt_r == CNT_W'(HDR_LEN - 1));

  // header fields, with the incoming byte as the last one on completion
  assign last_byte = hdr_done ? in_byte : hdr_r[HDR_LEN-1];
  assign len_view  = {hdr_r[0], hdr_r[1], hdr_r[2]};
  assign sid_view  = {hdr_r[5][6:0], hdr_r[6], hdr_r[7], last_byte};

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_size_r <= MAX_FRAME_RESET;
    end else if (cfg_wr_en) begin
      max_size_r <= cfg_wr_data;
    end
  end

  // decode of one accepted byte
  always_comb begin
    hdr_cnt_nxt    = hdr_cnt_r;
    rem_nxt        = rem_r;
    in_payload_nxt = in_payload_r;
    failed_nxt     = failed_r;
    push_valid     = 1'b0;

    res.kind          = KIND_HEADER;
    res.frame_length  = len_view;
    res.frame_type    = hdr_r[3];
    res.frame_flags   = hdr_r[4];
    res.sid           = sid_view;
    res.data_byte     = 8'd0;
    res.last_of_frame = 1'b0;

    if (accept && !failed_r) begin
      if (in_payload_r) begin
        push_valid        = 1'b1;
        res.kind          = KIND_PAYLOAD;
        res.data_byte     = in_byte;
        res.last_of_frame = (rem_r <= LEN_W'(1));
        rem_nxt           = rem_r - LEN_W'(1);
        if (rem_r <= LEN_W'(1)) begin
          in_payload_nxt = 1'b0;
        end
      end else if (hdr_done) begin
        push_valid  = 1'b1;
        hdr_cnt_nxt = '0;
        if (len_view > max_size_r) begin
          res.kind   = KIND_ERROR;
          failed_nxt = 1'b1;
        end else if (len_view == '0) begin
          res.last_of_frame = 1'b1;
        end else begin
          rem_nxt        = len_view;
          in_payload_nxt = 1'b1;
        end
      end else begin
        hdr_cnt_nxt = hdr_cnt_r + CNT_W'(1);
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_cnt_r    <= '0;
      rem_r        <= '0;
      in_payload_r <= 1'b0;
      failed_r     <= 1'b0;
    end else begin
      hdr_cnt_r    <= hdr_cnt_nxt;
      rem_r        <= rem_nxt;
      in_payload_r <= in_payload_nxt;
      failed_r     <= failed_nxt;
    end
  end

  // header byte store
  always_ff @(posedge clk) begin
    if (accept && !failed_r && !in_payload_r) begin
      hdr_r[hdr_cnt_r] <= in_byte;
    end
  end

  // result register and skid stage
  fsd_skid u_skid (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_data  (res),
    .push_ready (push_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_res)
  );

  assign out_kind          = out_res.kind;
  assign out_frame_length  = out_res.frame_length;
  assign out_frame_type    = out_res.frame_type;
  assign out_frame_flags   = out_res.frame_flags;
  assign out_sid           = out_res.sid;
  assign out_data_byte     = out_res.data_byte;
  assign out_last_of_frame = out_res.last_of_frame;

`ifndef SYNTH
  // failure is sticky until reset
  a_failed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    failed_r |=> failed_r)
    else $error("failure flag cleared without reset");

  // header count never passes the header length
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    hdr_cnt_r <= CNT_W'(HDR_LEN - 1))
    else $error("header count out of range");

  // payload phase has bytes left and no partial header
  a_payload_state: assert property (@(posedge clk) disable iff (!rst_n)
    in_payload_r |-> (rem_r != '0) && (hdr_cnt_r == '0))
    else $error("inconsistent payload state");
`endif

endmodule
